/* design/nsag_pkg.sv */
`timescale 1ns / 1ps

package nsag_pkg;

    localparam int MAX_RANK       = 4;
    localparam int DIM_BITS       = 16;
    localparam int INDEX_BITS     = 32;

    localparam int CFG_WORD_BITS  = 64;
    localparam int RANK_REG_BITS  = 3;
    localparam int MASK_REG_BITS  = 4;
    localparam int REG_IDX_BITS   = 3;
    localparam int CFG_ADDR_BITS  = REG_IDX_BITS + 3;

    localparam int USED_RANK_BITS = $clog2(MAX_RANK + 1);
    localparam int AXIS_BITS      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RUN_BITS       = INDEX_BITS + 1;
    localparam int PROD_BITS      = RUN_BITS + DIM_BITS;
    localparam int NORM_BITS      = DIM_BITS + 2;

    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = ((2 * INDEX_BITS + 7) / 8) * 8;
    localparam int STATUS_BITS    = 2;

    // saturation cap of the element count products: 2^INDEX_BITS + 1
    localparam logic [PROD_BITS-1:0] RUN_CAP =
        (PROD_BITS'(1) << INDEX_BITS) + PROD_BITS'(1);

    localparam logic [REG_IDX_BITS-1:0] REG_RANK         = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_INPUT_DIMS   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SLICE_MASK   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SLICE_STARTS = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SLICE_ENDS   = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NONE     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [RANK_REG_BITS-1:0] rank;
        logic [CFG_WORD_BITS-1:0] input_dims;
        logic [MASK_REG_BITS-1:0] slice_mask;
        logic [CFG_WORD_BITS-1:0] slice_starts;
        logic [CFG_WORD_BITS-1:0] slice_ends;
    } nsag_cfg_t;

    typedef struct packed {
        logic load;        // restart: normalize and clear the walk state
        logic set_stride;
        logic set_base;
        logic step;        // advance the odometer by one element
        logic active;      // axis below the rank in use
    } nsag_cell_ctrl_t;

    // packed axis field; slots past the word read as zero
    function automatic logic [DIM_BITS-1:0] slot(logic [CFG_WORD_BITS-1:0] word, int axis);
        logic [CFG_WORD_BITS-1:0] shifted;
        shifted = word >> (axis * DIM_BITS);
        return shifted[DIM_BITS-1:0];
    endfunction

    function automatic logic mask_bit(logic [MASK_REG_BITS-1:0] mask, int axis);
        logic bit_val;
        bit_val = 1'b0;
        for (int i = 0; i < MASK_REG_BITS; i++)
        begin
            if (i == axis)
            begin
                bit_val = mask[i];
            end
        end
        return bit_val;
    endfunction

    function automatic logic [USED_RANK_BITS-1:0] used_rank(logic [RANK_REG_BITS-1:0] rank);
        logic [USED_RANK_BITS-1:0] r;
        if (rank == '0)
        begin
            r = USED_RANK_BITS'(1);
        end
        else if (int'(rank) > MAX_RANK)
        begin
            r = USED_RANK_BITS'(MAX_RANK);
        end
        else
        begin
            r = USED_RANK_BITS'(rank);
        end
        return r;
    endfunction

endpackage

/* design/nsag_cfg.sv */
`timescale 1ns / 1ps

module nsag_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nsag_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [nsag_pkg::CFG_WORD_BITS-1:0]   pwdata,
    output logic [nsag_pkg::CFG_WORD_BITS-1:0]   prdata,
    output logic                                 pready,
    output nsag_pkg::nsag_cfg_t                  cfg
);

    logic [nsag_pkg::RANK_REG_BITS-1:0] rank_reg;
    logic [nsag_pkg::CFG_WORD_BITS-1:0] input_dims_reg;
    logic [nsag_pkg::MASK_REG_BITS-1:0] slice_mask_reg;
    logic [nsag_pkg::CFG_WORD_BITS-1:0] slice_starts_reg;
    logic [nsag_pkg::CFG_WORD_BITS-1:0] slice_ends_reg;

    logic                                wr_en;
    logic [nsag_pkg::REG_IDX_BITS-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[nsag_pkg::CFG_ADDR_BITS-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg         <= nsag_pkg::RANK_REG_BITS'(1);
            input_dims_reg   <= '0;
            slice_mask_reg   <= '0;
            slice_starts_reg <= '0;
            slice_ends_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                nsag_pkg::REG_RANK:
                begin
                    rank_reg <= pwdata[nsag_pkg::RANK_REG_BITS-1:0];
                end
                nsag_pkg::REG_INPUT_DIMS:
                begin
                    input_dims_reg <= pwdata;
                end
                nsag_pkg::REG_SLICE_MASK:
                begin
                    slice_mask_reg <= pwdata[nsag_pkg::MASK_REG_BITS-1:0];
                end
                nsag_pkg::REG_SLICE_STARTS:
                begin
                    slice_starts_reg <= pwdata;
                end
                nsag_pkg::REG_SLICE_ENDS:
                begin
                    slice_ends_reg <= pwdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nsag_pkg::REG_RANK:
            begin
                prdata = nsag_pkg::CFG_WORD_BITS'(rank_reg);
            end
            nsag_pkg::REG_INPUT_DIMS:
            begin
                prdata = input_dims_reg;
            end
            nsag_pkg::REG_SLICE_MASK:
            begin
                prdata = nsag_pkg::CFG_WORD_BITS'(slice_mask_reg);
            end
            nsag_pkg::REG_SLICE_STARTS:
            begin
                prdata = slice_starts_reg;
            end
            nsag_pkg::REG_SLICE_ENDS:
            begin
                prdata = slice_ends_reg;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.rank         = rank_reg;
    assign cfg.input_dims   = input_dims_reg;
    assign cfg.slice_mask   = slice_mask_reg;
    assign cfg.slice_starts = slice_starts_reg;
    assign cfg.slice_ends   = slice_ends_reg;

endmodule

/* design/nsag_cell.sv */
`timescale 1ns / 1ps

module nsag_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nsag_pkg::nsag_cell_ctrl_t          ctrl,
    input  logic [nsag_pkg::DIM_BITS-1:0]      dim,
    input  logic [nsag_pkg::DIM_BITS-1:0]      slice_start,
    input  logic [nsag_pkg::DIM_BITS-1:0]      slice_end,
    input  logic                               sliced,
    input  logic [nsag_pkg::INDEX_BITS-1:0]    stride_in,
    input  logic [nsag_pkg::INDEX_BITS-1:0]    base_in,
    input  logic                               carry_in,
    input  logic                               done_in,
    input  logic [nsag_pkg::INDEX_BITS-1:0]    sum_in,
    output logic                               carry_out,
    output logic                               done_out,
    output logic                               extent_zero,
    output logic [nsag_pkg::DIM_BITS-1:0]      start,
    output logic [nsag_pkg::INDEX_BITS-1:0]    sum_out
);

    localparam int NB = nsag_pkg::NORM_BITS;
    localparam int DB = nsag_pkg::DIM_BITS;
    localparam int IB = nsag_pkg::INDEX_BITS;

    logic [DB-1:0] counter_reg, counter_next;
    logic [DB-1:0] start_reg,   start_next;
    logic [DB-1:0] extent_reg,  extent_next;
    logic [IB-1:0] stride_reg,  stride_next;
    logic [IB-1:0] base_reg,    base_next;
    logic [IB-1:0] term_reg,    term_next;   // (start + counter) * stride

    logic signed [NB-1:0] dim_n, s_norm, e_norm, span;
    logic                 nonempty;
    logic [DB-1:0]        start_load, extent_load;
    logic [DB:0]          cnt_inc;
    logic                 wrap, at_end;

    // slice normalization at restart
    always_comb
    begin
        dim_n  = signed'(NB'(dim));
        s_norm = '0;
        e_norm = dim_n;
        if (sliced && (dim != '0))
        begin
            s_norm = signed'({{2{slice_start[DB-1]}}, slice_start});
            e_norm = signed'({{2{slice_end[DB-1]}}, slice_end});
            if (s_norm < 0)
            begin
                s_norm = s_norm + dim_n;
            end
            if (e_norm < 0)
            begin
                e_norm = e_norm + dim_n;
            end
            if (s_norm < 0)
            begin
                s_norm = '0;
            end
            if (e_norm < 0)
            begin
                e_norm = '0;
            end
            if (e_norm > dim_n)
            begin
                e_norm = dim_n;
            end
        end
        span        = e_norm - s_norm;
        nonempty    = e_norm > s_norm;
        start_load  = nonempty ? s_norm[DB-1:0] : '0;
        extent_load = nonempty ? span[DB-1:0]   : '0;
    end

    assign cnt_inc     = {1'b0, counter_reg} + (DB+1)'(1);
    assign wrap        = cnt_inc >= {1'b0, extent_reg};
    assign at_end      = cnt_inc == {1'b0, extent_reg};
    assign carry_out   = ctrl.active ? (carry_in & wrap) : carry_in;
    assign done_out    = done_in & (~ctrl.active | at_end);
    assign sum_out     = sum_in + (ctrl.active ? term_reg : '0);
    assign extent_zero = extent_reg == '0;
    assign start       = start_reg;

    always_comb
    begin
        counter_next = counter_reg;
        start_next   = start_reg;
        extent_next  = extent_reg;
        stride_next  = stride_reg;
        base_next    = base_reg;
        term_next    = term_reg;
        if (ctrl.load)
        begin
            counter_next = '0;
            start_next   = ctrl.active ? start_load  : '0;
            extent_next  = ctrl.active ? extent_load : '0;
            stride_next  = '0;
            base_next    = '0;
            term_next    = '0;
        end
        else
        begin
            if (ctrl.set_stride)
            begin
                stride_next = stride_in;
            end
            if (ctrl.set_base)
            begin
                base_next = base_in;
                term_next = base_in;
            end
            if (ctrl.step && ctrl.active && carry_in)
            begin
                if (wrap)
                begin
                    counter_next = '0;
                    term_next    = base_reg;
                end
                else
                begin
                    counter_next = cnt_inc[DB-1:0];
                    term_next    = term_reg + stride_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            start_reg   <= '0;
            extent_reg  <= '0;
            stride_reg  <= '0;
            base_reg    <= '0;
            term_reg    <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            start_reg   <= start_next;
            extent_reg  <= extent_next;
            stride_reg  <= stride_next;
            base_reg    <= base_next;
            term_reg    <= term_next;
        end
    end

endmodule

/* design/nd_slice_address_generator.sv */
`timescale 1ns / 1ps
// Advance request (restart = 0): result registered, valid the cycle after the request;
//   one advance accepted per cycle while idle and the result side keeps taking.
// Restart request: result registered after the setup sequencer has run (rank as used, 1 to 4),
//   held further while the result side stalls; the sequencer runs one shared multiplier over
//   the axes, S_MUL_DIM, S_MUL_START and S_SET_BASE per axis, then S_FINISH issues the result.
// Reset (rst_n, async, active low): no walk, output empty, registers at reset values.

module nd_slice_address_generator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [nsag_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,   // [0] restart
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [nsag_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,   // src_index, dst_index
    output logic                                    m_axis_tlast,
    output logic [nsag_pkg::STATUS_BITS-1:0]        m_axis_tuser,   // status
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [nsag_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [nsag_pkg::CFG_WORD_BITS-1:0]      pwdata,
    output logic [nsag_pkg::CFG_WORD_BITS-1:0]      prdata,
    output logic                                    pready
);

    localparam int MR = nsag_pkg::MAX_RANK;
    localparam int IB = nsag_pkg::INDEX_BITS;
    localparam int DB = nsag_pkg::DIM_BITS;
    localparam int AB = nsag_pkg::AXIS_BITS;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_DIM   = 3'd1;
    localparam logic [2:0] S_MUL_START = 3'd2;
    localparam logic [2:0] S_SET_BASE  = 3'd3;
    localparam logic [2:0] S_FINISH    = 3'd4;

    nsag_pkg::nsag_cfg_t cfg;

    logic [2:0]                        state_reg, state_next;
    logic [AB-1:0]                     axis_reg, axis_next;
    logic [nsag_pkg::RUN_BITS-1:0]     run_reg, run_next;
    logic [nsag_pkg::PROD_BITS-1:0]    prod_reg, prod_next;
    logic                              walk_reg, walk_next;
    logic [IB-1:0]                     dst_reg, dst_next;

    logic                              m_valid_reg, m_valid_next;
    logic [IB-1:0]                     m_src_reg, m_src_next;
    logic [IB-1:0]                     m_dst_reg, m_dst_next;
    logic                              m_last_reg, m_last_next;
    logic [nsag_pkg::STATUS_BITS-1:0]  m_status_reg, m_status_next;

    logic [nsag_pkg::USED_RANK_BITS-1:0] r_used;
    logic                              in_accept, out_free;
    logic                              restart_req, advance_req;
    logic                              overflow, empty, fin, fin_ok, do_step, emit;
    logic [nsag_pkg::RUN_BITS-1:0]     mul_a;
    logic [DB-1:0]                     mul_b;

    logic [MR:0]                       carry_chain, done_chain;
    logic [IB-1:0]                     sum_chain [MR+1];
    logic [DB-1:0]                     dim_slot [MR];
    logic [DB-1:0]                     cell_start [MR];
    logic [MR-1:0]                     cell_empty;
    nsag_pkg::nsag_cell_ctrl_t         cell_ctrl [MR];

    nsag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign r_used = nsag_pkg::used_rank(cfg.rank);

    // odometer: innermost axis sits at the high end of the chain
    assign carry_chain[MR] = 1'b1;
    assign done_chain[MR]  = 1'b1;
    assign sum_chain[MR]   = '0;

    generate
        for (genvar a = 0; a < MR; a++)
        begin : g_axis
            assign dim_slot[a]             = nsag_pkg::slot(cfg.input_dims, a);
            assign cell_ctrl[a].load       = restart_req;
            assign cell_ctrl[a].set_stride = (state_reg == S_MUL_DIM) && (axis_reg == AB'(a));
            assign cell_ctrl[a].set_base   = (state_reg == S_SET_BASE) && (axis_reg == AB'(a));
            assign cell_ctrl[a].step       = do_step & ~fin;
            assign cell_ctrl[a].active     = a < int'(r_used);

            nsag_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl[a]),
                .dim         (dim_slot[a]),
                .slice_start (nsag_pkg::slot(cfg.slice_starts, a)),
                .slice_end   (nsag_pkg::slot(cfg.slice_ends, a)),
                .sliced      (nsag_pkg::mask_bit(cfg.slice_mask, a)),
                .stride_in   (run_reg[IB-1:0]),
                .base_in     (prod_reg[IB-1:0]),
                .carry_in    (carry_chain[a+1]),
                .done_in     (done_chain[a+1]),
                .sum_in      (sum_chain[a+1]),
                .carry_out   (carry_chain[a]),
                .done_out    (done_chain[a]),
                .extent_zero (cell_empty[a]),
                .start       (cell_start[a]),
                .sum_out     (sum_chain[a])
            );
        end
    endgenerate

    assign fin = done_chain[0];

    always_comb
    begin
        empty = 1'b0;
        for (int a = 0; a < MR; a++)
        begin
            if (cell_ctrl[a].active && cell_empty[a])
            begin
                empty = 1'b1;
            end
        end
    end

    assign overflow    = run_reg[IB] & (|run_reg[IB-1:0]);
    assign out_free    = ~m_valid_reg | m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) & out_free;
    assign in_accept   = s_axis_tvalid & s_axis_tready;
    assign restart_req = in_accept & s_axis_tdata[0];
    assign advance_req = in_accept & ~s_axis_tdata[0];
    assign fin_ok      = (state_reg == S_FINISH) & out_free & ~overflow & ~empty;
    assign do_step     = (advance_req & walk_reg) | fin_ok;
    assign emit        = advance_req | ((state_reg == S_FINISH) & out_free);

    // shared multiplier: running stride times the axis dimension, then stride times start
    always_comb
    begin
        if (state_reg == S_MUL_DIM)
        begin
            mul_a = run_reg;
            mul_b = dim_slot[axis_reg];
        end
        else
        begin
            mul_a = {1'b0, run_reg[IB-1:0]};
            mul_b = cell_start[axis_reg];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        run_next   = run_reg;
        prod_next  = prod_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (restart_req)
                begin
                    axis_next  = AB'(r_used - 1'b1);
                    run_next   = nsag_pkg::RUN_BITS'(1);
                    state_next = S_MUL_DIM;
                end
            end
            S_MUL_DIM:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MUL_START;
            end
            S_MUL_START:
            begin
                run_next   = (prod_reg > nsag_pkg::RUN_CAP) ?
                             nsag_pkg::RUN_CAP[nsag_pkg::RUN_BITS-1:0] :
                             prod_reg[nsag_pkg::RUN_BITS-1:0];
                prod_next  = mul_a * mul_b;
                state_next = S_SET_BASE;
            end
            S_SET_BASE:
            begin
                if (axis_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    axis_next  = axis_reg - 1'b1;
                    state_next = S_MUL_DIM;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        walk_next = walk_reg;
        dst_next  = dst_reg;
        if (restart_req)
        begin
            walk_next = 1'b0;
        end
        else if (fin_ok)
        begin
            dst_next  = '0;
            walk_next = ~fin;
        end
        else if (do_step)
        begin
            dst_next  = dst_reg + IB'(1);
            walk_next = ~fin;
        end
    end

    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_src_next    = m_src_reg;
        m_dst_next    = m_dst_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            if (do_step)
            begin
                m_src_next    = sum_chain[0];
                m_dst_next    = dst_next;
                m_last_next   = fin;
                m_status_next = nsag_pkg::STATUS_OK;
            end
            else
            begin
                m_src_next    = '0;
                m_dst_next    = '0;
                m_last_next   = 1'b0;
                m_status_next = ((state_reg == S_FINISH) && overflow) ?
                                nsag_pkg::STATUS_OVERFLOW : nsag_pkg::STATUS_NONE;
            end
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            axis_reg     <= '0;
            run_reg      <= '0;
            prod_reg     <= '0;
            walk_reg     <= 1'b0;
            dst_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_src_reg    <= '0;
            m_dst_reg    <= '0;
            m_last_reg   <= 1'b0;
            m_status_reg <= nsag_pkg::STATUS_OK;
        end
        else
        begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            run_reg      <= run_next;
            prod_reg     <= prod_next;
            walk_reg     <= walk_next;
            dst_reg      <= dst_next;
            m_valid_reg  <= m_valid_next;
            m_src_reg    <= m_src_next;
            m_dst_reg    <= m_dst_next;
            m_last_reg   <= m_last_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = nsag_pkg::OUT_TDATA_BITS'({m_dst_reg, m_src_reg});
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

/* design/nsag_checker.sv */
`timescale 1ns / 1ps

module nsag_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [nsag_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [nsag_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input logic                                 m_axis_tlast,
    input logic [nsag_pkg::STATUS_BITS-1:0]     m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no element: indexes and last are zero
    a_no_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != nsag_pkg::STATUS_OK) |->
            (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("non-element result carries index data");

    // an advance request answers in the next cycle
    a_advance_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] |=> m_axis_tvalid)
        else $error("advance request got no result");

    // no request taken while the result register is blocked
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken with result blocked");

endmodule

bind nd_slice_address_generator nsag_checker u_nsag_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
